// ===== design/pfbm_pkg.sv =====
// Package for the page frame buffer manager: sizes, payload structs, codes and
// the command and status structs between the controller and the datapath.
// Depends on nothing; every other design file uses it by scoped names.
package pfbm_pkg;

	localparam int FRAMES     = 64;
	localparam int GEN_BITS   = 16;
	localparam int PIN_BITS   = 8;
	localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [GEN_BITS-1:0]   gen_t;
	typedef logic [PIN_BITS-1:0]   pin_t;

	localparam pin_t PIN_MAX = '1;

	// Operation codes of a request beat.
	localparam logic [1:0] OP_GET     = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_DIRTY   = 2'd2;
	localparam logic [1:0] OP_NOP     = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_LEFT_GEN  = 1'b0;
	localparam logic CFG_RIGHT_GEN = 1'b1;

	typedef enum logic [2:0] {
		ST_OK               = 3'd0,
		ST_NO_FRAME         = 3'd1,
		ST_RELEASE_UNPINNED = 3'd2,
		ST_INACTIVE_GEN     = 3'd3,
		ST_PIN_OVERFLOW     = 3'd4
	} status_e;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] page_number;
		logic [15:0] generation;
		logic        fresh_page;
		logic [5:0]  frame_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  frame_out;
		logic        hit;
		logic        writeback_valid;
		logic [31:0] writeback_page;
		logic        writeback_pool;
		logic        fill_valid;
		logic        fill_pool;
	} rsp_t;

	// One row of the frame table.
	typedef struct packed {
		logic [31:0] page;
		gen_t        gen;
		pin_t        pin;
		logic        dirty;
	} row_t;

	typedef enum logic [2:0] {
		ADDR_HOLD,
		ADDR_ZERO,
		ADDR_VICTIM,
		ADDR_FIDX,
		ADDR_NEXT
	} addr_sel_e;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_PIN_INC,
		WR_PIN_DEC,
		WR_DIRTY,
		WR_INSTALL
	} wr_e;

	typedef enum logic [1:0] {
		FRM_ZERO,
		FRM_ADDR,
		FRM_FIDX
	} frm_sel_e;

	typedef struct packed {
		logic      load_req;
		addr_sel_e addr_sel;
		logic      rd;
		wr_e       wr;
		logic      res_load;
		status_e   res_status;
		frm_sel_e  res_frame;
		logic      res_hit;
		logic      res_evict;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       fidx_ok;
		logic       tag_hit;
		logic       pin_zero;
		logic       pin_full;
		logic       miss_ok;
		logic       scan_last;
		logic       out_free;
	} stat_t;

	// Returns {found, pool}: pool 0 is left, 1 is right; left is tried first.
	function automatic logic [1:0] pool_lookup(gen_t g, logic [15:0] left_gen,
			logic [15:0] right_gen);
		logic [1:0] res;
		res = 2'b00;
		if (g != '0) begin
			if (g == gen_t'(left_gen)) begin
				res = 2'b10;
			end else if (g == gen_t'(right_gen)) begin
				res = 2'b11;
			end
		end
		return res;
	endfunction

endpackage

// ===== design/pfbm_ctrl.sv =====
// Controller state machine of the page frame buffer manager.
// Depends on pfbm_pkg; drives pfbm_datapath through cmd_t and reads stat_t.
module pfbm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pfbm_pkg::stat_t stat,
	output pfbm_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_LOOK_RD,
		S_LOOK_CHK,
		S_VIC_RD,
		S_VIC_CHK,
		S_FRM_RD,
		S_FRM_CHK,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.addr_sel = pfbm_pkg::ADDR_HOLD;
		cmd.wr = pfbm_pkg::WR_NONE;
		cmd.res_status = pfbm_pkg::ST_OK;
		cmd.res_frame = pfbm_pkg::FRM_ZERO;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_nxt = S_START;
				end
			end
			S_START: begin
				case (stat.op)
					pfbm_pkg::OP_GET: begin
						cmd.addr_sel = pfbm_pkg::ADDR_ZERO;
						state_nxt = S_LOOK_RD;
					end
					pfbm_pkg::OP_RELEASE, pfbm_pkg::OP_DIRTY: begin
						if (stat.fidx_ok) begin
							cmd.addr_sel = pfbm_pkg::ADDR_FIDX;
							state_nxt = S_FRM_RD;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_frame = pfbm_pkg::FRM_FIDX;
							cmd.res_status = (stat.op == pfbm_pkg::OP_RELEASE) ?
								pfbm_pkg::ST_RELEASE_UNPINNED : pfbm_pkg::ST_OK;
							state_nxt = S_FINISH;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						state_nxt = S_FINISH;
					end
				endcase
			end
			S_LOOK_RD: begin
				cmd.rd = 1'b1;
				state_nxt = S_LOOK_CHK;
			end
			S_LOOK_CHK: begin
				if (stat.tag_hit) begin
					cmd.res_load = 1'b1;
					cmd.res_hit = 1'b1;
					cmd.res_frame = pfbm_pkg::FRM_ADDR;
					if (stat.pin_full) begin
						cmd.res_status = pfbm_pkg::ST_PIN_OVERFLOW;
					end else begin
						cmd.wr = pfbm_pkg::WR_PIN_INC;
					end
					state_nxt = S_FINISH;
				end else if (stat.scan_last) begin
					if (stat.miss_ok) begin
						cmd.addr_sel = pfbm_pkg::ADDR_VICTIM;
						state_nxt = S_VIC_RD;
					end else begin
						cmd.res_load = 1'b1;
						cmd.res_status = pfbm_pkg::ST_INACTIVE_GEN;
						state_nxt = S_FINISH;
					end
				end else begin
					cmd.addr_sel = pfbm_pkg::ADDR_NEXT;
					state_nxt = S_LOOK_RD;
				end
			end
			S_VIC_RD: begin
				cmd.rd = 1'b1;
				state_nxt = S_VIC_CHK;
			end
			S_VIC_CHK: begin
				if (stat.pin_zero) begin
					cmd.wr = pfbm_pkg::WR_INSTALL;
					cmd.res_load = 1'b1;
					cmd.res_evict = 1'b1;
					cmd.res_frame = pfbm_pkg::FRM_ADDR;
					state_nxt = S_FINISH;
				end else if (stat.scan_last) begin
					cmd.res_load = 1'b1;
					cmd.res_status = pfbm_pkg::ST_NO_FRAME;
					state_nxt = S_FINISH;
				end else begin
					cmd.addr_sel = pfbm_pkg::ADDR_NEXT;
					state_nxt = S_VIC_RD;
				end
			end
			S_FRM_RD: begin
				cmd.rd = 1'b1;
				state_nxt = S_FRM_CHK;
			end
			S_FRM_CHK: begin
				cmd.res_load = 1'b1;
				cmd.res_frame = pfbm_pkg::FRM_FIDX;
				if (stat.op == pfbm_pkg::OP_RELEASE) begin
					if (stat.pin_zero) begin
						cmd.res_status = pfbm_pkg::ST_RELEASE_UNPINNED;
					end else begin
						cmd.wr = pfbm_pkg::WR_PIN_DEC;
					end
				end else begin
					cmd.wr = pfbm_pkg::WR_DIRTY;
				end
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/pfbm_datapath.sv =====
// Datapath of the page frame buffer manager: frame table memory, valid bits,
// scan address, victim pointer, pool registers and the result registers.
// Depends on pfbm_pkg; commanded by pfbm_ctrl.
module pfbm_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  pfbm_pkg::req_t  req,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            rsp_stall,
	input  pfbm_pkg::cmd_t  cmd,
	output pfbm_pkg::stat_t stat,
	output pfbm_pkg::rsp_t  rsp,
	output logic            rsp_valid
);

	localparam pfbm_pkg::frame_t LAST_FRAME = pfbm_pkg::frame_t'(pfbm_pkg::FRAMES - 1);

	pfbm_pkg::req_t   req_q;
	logic [15:0]      left_gen_q;
	logic [15:0]      right_gen_q;
	pfbm_pkg::frame_t addr_q;
	pfbm_pkg::frame_t cnt_q;
	pfbm_pkg::frame_t victim_q;
	logic [pfbm_pkg::FRAMES-1:0] vld_q;
	pfbm_pkg::row_t   tag_mem_q [pfbm_pkg::FRAMES];
	pfbm_pkg::row_t   row_q;
	logic             row_vld_q;
	pfbm_pkg::rsp_t   res_q;
	pfbm_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	pfbm_pkg::row_t   rv;
	pfbm_pkg::row_t   new_row;
	pfbm_pkg::gen_t   req_gen;
	pfbm_pkg::frame_t fidx;
	pfbm_pkg::frame_t next_addr;
	logic [1:0]       req_pool;
	logic [1:0]       vic_pool;
	logic             wb_hit;

	assign req_gen   = pfbm_pkg::gen_t'(req_q.generation);
	assign fidx      = pfbm_pkg::frame_t'(req_q.frame_index);
	assign next_addr = (addr_q == LAST_FRAME) ? '0 : pfbm_pkg::frame_t'(addr_q + 1'b1);
	// A row never written reads as the reset value, all zero.
	assign rv        = row_vld_q ? row_q : '0;
	assign req_pool  = pfbm_pkg::pool_lookup(req_gen, left_gen_q, right_gen_q);
	assign vic_pool  = pfbm_pkg::pool_lookup(rv.gen, left_gen_q, right_gen_q);
	assign wb_hit    = (rv.gen != '0) && rv.dirty && vic_pool[1];

	always_comb begin
		stat.op        = req_q.operation;
		stat.fidx_ok   = (32'(req_q.frame_index) < 32'(pfbm_pkg::FRAMES));
		stat.tag_hit   = (rv.gen != '0) && (rv.gen == req_gen) &&
			(rv.page == req_q.page_number);
		stat.pin_zero  = (rv.pin == '0);
		stat.pin_full  = (rv.pin == pfbm_pkg::PIN_MAX);
		stat.miss_ok   = req_q.fresh_page || req_pool[1];
		stat.scan_last = (cnt_q == LAST_FRAME);
		stat.out_free  = !rsp_valid_q || !rsp_stall;
	end

	always_comb begin
		new_row = rv;
		case (cmd.wr)
			pfbm_pkg::WR_PIN_INC: new_row.pin = pfbm_pkg::pin_t'(rv.pin + 1'b1);
			pfbm_pkg::WR_PIN_DEC: new_row.pin = pfbm_pkg::pin_t'(rv.pin - 1'b1);
			pfbm_pkg::WR_DIRTY:   new_row.dirty = 1'b1;
			pfbm_pkg::WR_INSTALL: begin
				new_row.page  = req_q.page_number;
				new_row.gen   = req_gen;
				new_row.pin   = pfbm_pkg::pin_t'(1);
				new_row.dirty = 1'b0;
			end
			default: new_row = rv;
		endcase
	end

	// Frame table: one read or one write per cycle at the scan address.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			row_q     <= tag_mem_q[addr_q];
			row_vld_q <= vld_q[addr_q];
		end
		if (cmd.wr != pfbm_pkg::WR_NONE) begin
			tag_mem_q[addr_q] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		case (cmd.addr_sel)
			pfbm_pkg::ADDR_ZERO: begin
				addr_q <= '0;
				cnt_q  <= '0;
			end
			pfbm_pkg::ADDR_VICTIM: begin
				addr_q <= victim_q;
				cnt_q  <= '0;
			end
			pfbm_pkg::ADDR_FIDX: begin
				addr_q <= fidx;
				cnt_q  <= '0;
			end
			pfbm_pkg::ADDR_NEXT: begin
				addr_q <= next_addr;
				cnt_q  <= pfbm_pkg::frame_t'(cnt_q + 1'b1);
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
		if (cmd.res_load) begin
			res_q.status <= cmd.res_status;
			case (cmd.res_frame)
				pfbm_pkg::FRM_ADDR: res_q.frame_out <= 6'(addr_q);
				pfbm_pkg::FRM_FIDX: res_q.frame_out <= req_q.frame_index;
				default:            res_q.frame_out <= '0;
			endcase
			res_q.hit             <= cmd.res_hit;
			res_q.writeback_valid <= cmd.res_evict && wb_hit;
			res_q.writeback_page  <= (cmd.res_evict && wb_hit) ? rv.page : '0;
			res_q.writeback_pool  <= cmd.res_evict && wb_hit && vic_pool[0];
			res_q.fill_valid      <= cmd.res_evict && !req_q.fresh_page;
			res_q.fill_pool       <= cmd.res_evict && !req_q.fresh_page && req_pool[0];
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_gen_q  <= 16'd1;
			right_gen_q <= 16'd0;
			victim_q    <= '0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pfbm_pkg::CFG_LEFT_GEN:  left_gen_q  <= cfg_data;
					pfbm_pkg::CFG_RIGHT_GEN: right_gen_q <= cfg_data;
					default:                 left_gen_q  <= left_gen_q;
				endcase
			end
			if (cmd.wr != pfbm_pkg::WR_NONE) begin
				vld_q[addr_q] <= 1'b1;
			end
			if (cmd.wr == pfbm_pkg::WR_INSTALL) begin
				victim_q <= next_addr;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/page_frame_buffer_manager.sv =====
// Top level of the page frame buffer manager: request, response and
// configuration channels around the controller and the datapath.
// Depends on pfbm_pkg, pfbm_ctrl and pfbm_datapath.
//
//  Channel   Handshake              Beat contents
//  request   req_valid / req_stall  req (operation, page, generation, fresh, frame)
//  response  rsp_valid / rsp_stall  rsp (status, frame, hit, write-back, fill)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data (pool generations)
//
// The frame table is a single-port memory; each row is read in a read state
// and checked in a check state. A get scans from frame 0 until a hit; a miss
// scans all FRAMES rows for a hit and then walks from the victim pointer past
// pinned frames; release and mark-dirty work on the named row. The request
// channel stalls while a beat is in work; a finished response waits in the
// output register, and a stalled response holds the block in its final step.
// Reset clears the row valid bits at once, so no clearing pass is needed.
module page_frame_buffer_manager (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  pfbm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pfbm_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [15:0]    cfg_data
);

	pfbm_pkg::cmd_t  cmd;
	pfbm_pkg::stat_t stat;

	// Pool registers are plain flops, so a write is always taken.
	assign cfg_ready = 1'b1;

	pfbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfbm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule
